// ===== hw/rtl/radix2_autosort_fft_assert.svh =====
// assertion macros shared by the checker
`ifndef RADIX2_AUTOSORT_FFT_ASSERT_SVH
`define RADIX2_AUTOSORT_FFT_ASSERT_SVH
// property that holds every edge outside reset
`define R2F_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// implication checked at the next edge
`define R2F_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/r2f_pkg.sv =====
`default_nettype none
package r2f_pkg;
  // request modes
  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeRun  = 2'd1,
    ModeRead = 2'd2,
    ModeNone = 2'd3
  } mode_e;

  localparam int unsigned SampleW = 16;
  localparam int unsigned BinW    = 30;
  localparam int unsigned IndexW  = 10;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StTwid  = 6'b000010,
    StRdA   = 6'b000100,
    StMul   = 6'b001000,
    StWrLo  = 6'b010000,
    StWrHi  = 6'b100000
  } state_e;

  typedef struct packed {
    logic signed [SampleW-1:0] re;
    logic signed [SampleW-1:0] im;
  } cplx_t;

  // saturate a 19-bit value to 16 bits
  function automatic logic signed [SampleW-1:0] sat16(input logic signed [18:0] x);
    if (x > 19'sd32767) return 16'sd32767;
    if (x < -19'sd32768) return -16'sd32768;
    return x[SampleW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/radix2_autosort_fft.sv =====
// Stockham radix-2 FFT over Points complex 16-bit samples, natural order in
// and out. Mode 0 loads a sample, mode 1 runs the transform and answers with
// done_res_o set, mode 2 reads a bin (scaled by Points after a forward run).
// A read answers through the memory read register and then the output
// register, and holds the input off while the memory read is pending. A run
// uses one shared butterfly unit (complex multiply, then add/subtract and
// halving) and two buffer memories; each butterfly steps through address and
// twiddle lookup, operand capture, multiply and two writes. No request is
// accepted during a run, nor while a result waits under out_stall_i. Both
// buffers are undefined after reset until loaded.
`default_nettype none
module radix2_autosort_fft #(
  parameter int unsigned Points = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [r2f_pkg::IndexW-1:0] index_i,
  input  wire logic signed [r2f_pkg::SampleW-1:0] sample_real_i,
  input  wire logic signed [r2f_pkg::SampleW-1:0] sample_imag_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [r2f_pkg::BinW-1:0] bin_real_o,
  output logic signed [r2f_pkg::BinW-1:0] bin_imag_o,
  output logic             done_res_o
);
  localparam int unsigned Lg = $clog2(Points);
  localparam int unsigned AW = Lg;

  r2f_pkg::state_e state_q, state_d;
  logic inverse_q, fwd_q, sel_q;
  logic [Lg-1:0] len_lg_q;   // stage number = log2(len)
  logic [AW-2:0] bf_q;       // butterfly counter within stage
  logic rd_pend_q;
  logic run_last;

  // memories
  r2f_pkg::cplx_t mem0 [Points];
  r2f_pkg::cplx_t mem1 [Points];
  r2f_pkg::cplx_t rd0a_q, rd0b_q, rd1a_q, rd1b_q;

  logic [AW-1:0] ra, rb, wa, wlo_addr, whi_addr;
  logic          we0, we1;
  r2f_pkg::cplx_t wd;

  // butterfly index split: bf = k*len + j
  logic [AW-2:0] jmask, j_idx, k_len;
  logic [AW-1:0] len;
  assign len   = AW'(1) << len_lg_q;
  assign jmask = (AW-1)'(len - AW'(1));
  assign j_idx = bf_q & jmask;
  assign k_len = bf_q & ~jmask;
  assign ra = {1'b0, bf_q};
  assign rb = {1'b1, bf_q};
  assign wlo_addr = {k_len, 1'b0} | {1'b0, j_idx};
  assign whi_addr = wlo_addr + len;

  // last butterfly of the last stage
  assign run_last = (state_q == r2f_pkg::StWrHi) && (&bf_q) && (len_lg_q == Lg'(Lg - 1));

  // twiddle index j*groups = j << (Lg-1-stage)
  logic [Lg-1:0] tw_k;
  logic signed [15:0] wc, ws, wi_eff;
  assign tw_k = Lg'({1'b0, j_idx} << (Lg - 1 - len_lg_q));
  r2f_twiddle_rom #(.Points(Points)) u_rom (.clk_i(clk_i), .k_i(tw_k),
    .cos_o(wc), .sin_o(ws));
  assign wi_eff = inverse_q ? ws : -ws;

  logic accept;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != r2f_pkg::StIdle) || rd_pend_q ||
                      (out_valid_o && out_stall_i);

  logic [AW-1:0] idx;
  assign idx = AW'(index_i);

  // operands from current source buffer
  r2f_pkg::cplx_t u, x;
  assign u = sel_q ? rd1a_q : rd0a_q;
  assign x = sel_q ? rd1b_q : rd0b_q;

  // multiply stage registers
  logic signed [15:0] wr_q, wi_q, ur_q, ui_q;
  logic signed [32:0] pr_q, pi_q;
  logic signed [17:0] vr, vi;
  logic signed [18:0] sr, si, dr, di;
  assign vr = 18'((pr_q + 33'sd16384) >>> 15);
  assign vi = 18'((pi_q + 33'sd16384) >>> 15);
  assign sr = 19'(ur_q) + 19'(vr);
  assign si = 19'(ui_q) + 19'(vi);
  assign dr = 19'(ur_q) - 19'(vr);
  assign di = 19'(ui_q) - 19'(vi);
  r2f_pkg::cplx_t lo_res, hi_res;
  assign lo_res.re = r2f_pkg::sat16(sr >>> 1);
  assign lo_res.im = r2f_pkg::sat16(si >>> 1);
  assign hi_res.re = r2f_pkg::sat16(dr >>> 1);
  assign hi_res.im = r2f_pkg::sat16(di >>> 1);

  // twiddle and operands are valid in the cycle after the addresses settle
  always_ff @(posedge clk_i) begin
    if (state_q == r2f_pkg::StRdA) begin
      wr_q <= wc;
      wi_q <= wi_eff;
      ur_q <= u.re;
      ui_q <= u.im;
    end
    if (state_q == r2f_pkg::StMul) begin
      pr_q <= 33'(wr_q * x.re) - 33'(wi_q * x.im);
      pi_q <= 33'(wr_q * x.im) + 33'(wi_q * x.re);
    end
  end

  // memory write mux
  always_comb begin
    wa = idx;
    wd.re = sample_real_i;
    wd.im = sample_imag_i;
    we0 = 1'b0;
    we1 = 1'b0;
    if (state_q == r2f_pkg::StIdle) begin
      if (accept && mode_i == r2f_pkg::ModeLoad) begin
        we0 = !sel_q;
        we1 = sel_q;
      end
    end else if (state_q == r2f_pkg::StWrLo || state_q == r2f_pkg::StWrHi) begin
      wa = (state_q == r2f_pkg::StWrLo) ? wlo_addr : whi_addr;
      wd = (state_q == r2f_pkg::StWrLo) ? lo_res : hi_res;
      we0 = sel_q;
      we1 = !sel_q;
    end
  end

  // buffer memories; port a reads for reads and butterflies
  logic [AW-1:0] rda;
  assign rda = (state_q == r2f_pkg::StIdle) ? idx : ra;
  always_ff @(posedge clk_i) begin
    if (we0) mem0[wa] <= wd;
    rd0a_q <= mem0[rda];
    rd0b_q <= mem0[rb];
  end
  always_ff @(posedge clk_i) begin
    if (we1) mem1[wa] <= wd;
    rd1a_q <= mem1[rda];
    rd1b_q <= mem1[rb];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      r2f_pkg::StIdle: if (accept && mode_i == r2f_pkg::ModeRun) state_d = r2f_pkg::StTwid;
      r2f_pkg::StTwid: state_d = r2f_pkg::StRdA;
      r2f_pkg::StRdA:  state_d = r2f_pkg::StMul;
      r2f_pkg::StMul:  state_d = r2f_pkg::StWrLo;
      r2f_pkg::StWrLo: state_d = r2f_pkg::StWrHi;
      r2f_pkg::StWrHi: begin
        if (run_last) state_d = r2f_pkg::StIdle;
        else state_d = r2f_pkg::StTwid;
      end
      default: state_d = r2f_pkg::StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= r2f_pkg::StIdle;
      inverse_q <= 1'b0;
      fwd_q <= 1'b0;
      sel_q <= 1'b0;
      len_lg_q <= '0;
      bf_q <= '0;
      rd_pend_q <= 1'b0;
      out_valid_o <= 1'b0;
      done_res_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) inverse_q <= cfg_wdata_i;
      rd_pend_q <= accept && (mode_i == r2f_pkg::ModeRead);
      // result valid: set by a read or the end of a run, cleared when taken
      if (rd_pend_q || run_last) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (rd_pend_q) begin
        done_res_o <= 1'b0;
      end else if (run_last) begin
        done_res_o <= 1'b1;
      end
      if (run_last) fwd_q <= !inverse_q;
      // butterfly and stage counters
      if (accept && mode_i == r2f_pkg::ModeRun) begin
        len_lg_q <= '0;
        bf_q <= '0;
      end else if (state_q == r2f_pkg::StWrHi) begin
        bf_q <= bf_q + 1'b1;
        if (&bf_q) begin
          sel_q <= !sel_q;
          len_lg_q <= len_lg_q + 1'b1;
        end
      end
    end
  end

  // output payload
  r2f_pkg::cplx_t rv;
  assign rv = sel_q ? rd1a_q : rd0a_q;
  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      bin_real_o <= fwd_q ? (30'(rv.re) <<< Lg) : 30'(rv.re);
      bin_imag_o <= fwd_q ? (30'(rv.im) <<< Lg) : 30'(rv.im);
    end else if (run_last) begin
      bin_real_o <= '0;
      bin_imag_o <= '0;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/r2f_twiddle_rom.sv =====
`default_nettype none
// quarter-wave twiddle table, Q1.15, built at elaboration by integer series
module r2f_twiddle_rom #(
  parameter int unsigned Points = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic [$clog2(Points)-1:0] k_i,
  output logic signed [15:0]             cos_o,
  output logic signed [15:0]             sin_o
);
  localparam int unsigned Lg = $clog2(Points);
  localparam int unsigned Quarter = Points / 4;
  localparam int unsigned Eighth = Points / 8;
  localparam int unsigned Half = Points / 2;
  localparam int unsigned QW = Lg - 2;

  // series term divisors 6, 20, 42, 72, 110 (sin) and 2, 12, 30, 56, 90 (cos)
  // as reciprocal multiply and shift, exact for terms below 2^30
  localparam int SinSh [5] = '{33, 35, 36, 37, 37};
  localparam int CosSh [5] = '{31, 34, 35, 36, 37};
  localparam longint SinM [5] = '{
    ((64'sd1 <<< 33) + 5) / 6,
    ((64'sd1 <<< 35) + 19) / 20,
    ((64'sd1 <<< 36) + 41) / 42,
    ((64'sd1 <<< 37) + 71) / 72,
    ((64'sd1 <<< 37) + 109) / 110
  };
  localparam longint CosM [5] = '{
    ((64'sd1 <<< 31) + 1) / 2,
    ((64'sd1 <<< 34) + 11) / 12,
    ((64'sd1 <<< 35) + 29) / 30,
    ((64'sd1 <<< 36) + 55) / 56,
    ((64'sd1 <<< 37) + 89) / 90
  };

  // q30 value clamped and rounded to q15
  function automatic logic [15:0] q30q15(input longint x);
    longint y;
    y = x;
    if (y < 0) y = 0;
    if (y > 64'sd1073741824) y = 64'sd1073741824;
    y = (y + 16384) >>> 15;
    if (y > 32767) y = 32767;
    return y[15:0];
  endfunction

  // cos (upper half) and sin (lower half) for angle index r of one octant
  function automatic logic [31:0] oct(input longint r);
    longint a, a2, t, sn, cs;
    logic [15:0] c16, s16;
    a = (r * 64'sd6746518852 + longint'(Half)) >>> Lg;
    a2 = (a * a) >>> 30;
    t = a;
    sn = a;
    for (int n = 0; n < 5; n++) begin
      t = (((t * a2) >>> 30) * SinM[n]) >>> SinSh[n];
      sn = n[0] ? sn + t : sn - t;
    end
    t = 64'sd1073741824;
    cs = t;
    for (int n = 0; n < 5; n++) begin
      t = (((t * a2) >>> 30) * CosM[n]) >>> CosSh[n];
      cs = n[0] ? cs + t : cs - t;
    end
    c16 = q30q15(cs);
    s16 = q30q15(sn);
    return {c16, s16};
  endfunction

  // first-quadrant entry: cos, sin
  function automatic logic [31:0] quad0(input longint r);
    logic [31:0] v;
    if (r <= longint'(Eighth)) return oct(r);
    v = oct(longint'(Quarter) - r);
    return {v[15:0], v[31:16]};
  endfunction

  logic [31:0] rom_q;
  logic [1:0]  quad_q;
  logic [QW-1:0] r;
  logic [31:0] rom_tab [Quarter];

  assign r = k_i[QW-1:0];

  // constant table, one entry per first-quadrant angle
  for (genvar g = 0; g < Quarter; g++) begin : g_tab
    assign rom_tab[g] = quad0(longint'(g));
  end

  // registered table read
  always_ff @(posedge clk_i) begin
    rom_q  <= rom_tab[r];
    quad_q <= k_i[Lg-1 -: 2];
  end

  // quadrant folding
  always_comb begin
    case (quad_q)
      2'd0: begin cos_o = rom_q[31:16]; sin_o = rom_q[15:0]; end
      2'd1: begin cos_o = -$signed(rom_q[15:0]); sin_o = rom_q[31:16]; end
      2'd2: begin cos_o = -$signed(rom_q[31:16]); sin_o = -$signed(rom_q[15:0]); end
      default: begin cos_o = rom_q[15:0]; sin_o = -$signed(rom_q[31:16]); end
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/r2f_checker.sv =====
`default_nettype none
`include "radix2_autosort_fft_assert.svh"
// port-level checks
module r2f_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic [1:0] mode_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic done_res_o,
  input wire logic signed [29:0] bin_real_o
);
  // a stalled result holds
  `R2F_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(bin_real_o), "stalled result changed")
  // a run result carries zero data
  `R2F_ASSERT(a_done_zero, !(out_valid_o && done_res_o) || bin_real_o == '0, "done not zero")
  // a run request blocks the next request
  `R2F_ASSERT_NEXT(a_run_busy, in_valid_i && !in_stall_o && mode_i == r2f_pkg::ModeRun, in_stall_o, "run did not stall input")
  // a load request produces no result next cycle from idle output
  `R2F_ASSERT_NEXT(a_load_quiet, in_valid_i && !in_stall_o && mode_i == r2f_pkg::ModeLoad && !out_valid_o, !out_valid_o, "load gave a result")
endmodule

bind radix2_autosort_fft r2f_checker u_chk (.*);
`default_nettype wire

// ===== dv/tb_radix2_autosort_fft.sv =====
module tb_radix2_autosort_fft;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned POINTS = 1024;
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;

  // idle schemes
  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_e;

  typedef struct {
    r2f_pkg::mode_e mode;
    logic [9:0] idx;
    logic signed [15:0] re;
    logic signed [15:0] im;
  } fft_req_t;

  typedef struct {
    logic signed [29:0] re;
    logic signed [29:0] im;
    logic done;
  } fft_bin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = 2'd0;
  logic [9:0] index_i = 10'd0;
  logic signed [15:0] sample_real_i = 16'sd0;
  logic signed [15:0] sample_imag_i = 16'sd0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [29:0] bin_real_o;
  logic signed [29:0] bin_imag_o;
  logic done_res_o;

  radix2_autosort_fft #(.Points(POINTS)) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .mode_i(mode_i),
    .index_i(index_i),
    .sample_real_i(sample_real_i),
    .sample_imag_i(sample_imag_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .bin_real_o(bin_real_o),
    .bin_imag_o(bin_imag_o),
    .done_res_o(done_res_o)
  );

  // predictor state
  r2f_pkg::cplx_t work_mem[POINTS];
  r2f_pkg::cplx_t stage_mem[POINTS];
  bit in_stage;
  bit last_fwd;
  bit inv_dir;
  bit written[POINTS];

  fft_req_t pending_reqs[$];
  fft_bin_t expected_bins[$];
  fft_req_t cur_req;
  idle_e idle_scheme = IdleNone;
  bit hold_go = 1'b0;
  bit hold_taken = 1'b0;
  int hold_cnt = 0;
  int mismatches = 0;
  int runs_seen = 0;
  int reads_seen = 0;
  int loads_seen = 0;
  int quiet_cycles = 0;

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int clip16(input longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return int'(x);
  endfunction

  function automatic int q30_q15(input longint x);
    longint y;
    y = x;
    if (y < 0) y = 0;
    if (y > Q30_ONE) y = Q30_ONE;
    y = (y + 16384) >>> 15;
    return (y > 32767) ? 32767 : int'(y);
  endfunction

  // cos and sin for angles up to one octant
  task automatic octant_trig(input longint unsigned r, output int c, output int s);
    longint unsigned a;
    longint unsigned a2;
    longint unsigned t;
    longint sn;
    longint cs;
    longint unsigned n;
    a = (r * TWO_PI_Q30 + POINTS / 2) / POINTS;
    a2 = (a * a) >> 30;
    t = a;
    sn = longint'(a);
    cs = Q30_ONE;
    for (n = 1; n <= 5; n++) begin
      t = ((t * a2) >> 30) / ((2 * n) * (2 * n + 1));
      sn = n[0] ? sn - longint'(t) : sn + longint'(t);
    end
    t = Q30_ONE;
    for (n = 1; n <= 5; n++) begin
      t = ((t * a2) >> 30) / ((2 * n - 1) * (2 * n));
      cs = n[0] ? cs - longint'(t) : cs + longint'(t);
    end
    c = q30_q15(cs);
    s = q30_q15(sn);
  endtask

  // full-circle twiddle by octant and quadrant symmetry
  task automatic twiddle_rom(input longint unsigned k, output int c, output int s);
    longint unsigned quarter;
    longint unsigned quad;
    longint unsigned r;
    int bc;
    int bs;
    quarter = POINTS / 4;
    k = k % POINTS;
    quad = k / quarter;
    r = k % quarter;
    if (r <= quarter / 2) octant_trig(r, bc, bs);
    else octant_trig(quarter - r, bs, bc);
    case (quad[1:0])
      2'd0: begin c = bc; s = bs; end
      2'd1: begin c = -bs; s = bc; end
      2'd2: begin c = -bc; s = -bs; end
      default: begin c = bs; s = -bc; end
    endcase
  endtask

  // stockham passes, ping-ponging between the two buffers
  task automatic transform_buffers();
    int unsigned len;
    int unsigned groups;
    int unsigned j;
    int unsigned k;
    int unsigned ia;
    int unsigned ib;
    int unsigned oa;
    int wr;
    int wi;
    longint ur, ui, xr, xi, vr, vi;
    r2f_pkg::cplx_t a;
    r2f_pkg::cplx_t b;
    r2f_pkg::cplx_t ra;
    r2f_pkg::cplx_t rb;
    for (len = 1; len < POINTS; len <<= 1) begin
      groups = POINTS / (len * 2);
      for (j = 0; j < len; j++) begin
        twiddle_rom(longint'(j) * groups, wr, wi);
        if (!inv_dir) wi = -wi;
        for (k = 0; k < groups; k++) begin
          ia = len * k + j;
          ib = ia + POINTS / 2;
          oa = 2 * len * k + j;
          a = in_stage ? stage_mem[ia] : work_mem[ia];
          b = in_stage ? stage_mem[ib] : work_mem[ib];
          ur = a.re; ui = a.im; xr = b.re; xi = b.im;
          vr = (longint'(wr) * xr - longint'(wi) * xi + 16384) >>> 15;
          vi = (longint'(wr) * xi + longint'(wi) * xr + 16384) >>> 15;
          ra.re = 16'(clip16((ur + vr) >>> 1));
          ra.im = 16'(clip16((ui + vi) >>> 1));
          rb.re = 16'(clip16((ur - vr) >>> 1));
          rb.im = 16'(clip16((ui - vi) >>> 1));
          if (in_stage) begin
            work_mem[oa] = ra;
            work_mem[oa + len] = rb;
          end else begin
            stage_mem[oa] = ra;
            stage_mem[oa + len] = rb;
          end
        end
      end
      in_stage = !in_stage;
    end
    last_fwd = !inv_dir;
  endtask

  // update the predictor for one accepted request
  task automatic predict_request(input fft_req_t rq);
    int unsigned i;
    fft_bin_t e;
    r2f_pkg::cplx_t v;
    longint sc;
    i = rq.idx % POINTS;
    case (rq.mode)
      r2f_pkg::ModeLoad: begin
        v.re = rq.re;
        v.im = rq.im;
        if (in_stage) stage_mem[i] = v;
        else work_mem[i] = v;
        loads_seen++;
      end
      r2f_pkg::ModeRun: begin
        transform_buffers();
        e.re = '0;
        e.im = '0;
        e.done = 1'b1;
        expected_bins.push_back(e);
        runs_seen++;
      end
      r2f_pkg::ModeRead: begin
        v = in_stage ? stage_mem[i] : work_mem[i];
        sc = last_fwd ? POINTS : 1;
        e.re = 30'(longint'(v.re) * sc);
        e.im = 30'(longint'(v.im) * sc);
        e.done = 1'b0;
        expected_bins.push_back(e);
        reads_seen++;
      end
      default: ;
    endcase
  endtask

  function automatic bit sender_idle();
    case (idle_scheme)
      IdleSender: return $urandom_range(99) < 71;
      IdleBoth: return $urandom_range(99) < 7;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_scheme)
      IdleReceiver: return $urandom_range(99) < 71;
      IdleBoth: return $urandom_range(99) < 7;
      default: return 1'b0;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_request(cur_req);
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() > 0 && !sender_idle()) begin
          cur_req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= cur_req.mode;
          index_i <= cur_req.idx;
          sample_real_i <= cur_req.re;
          sample_imag_i <= cur_req.im;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off counted here
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_go && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_cnt <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= receiver_stall();
      end
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    fft_bin_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_bins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: re %0d im %0d done %0b",
                     bin_real_o, bin_imag_o, done_res_o);
        end else begin
          e = expected_bins.pop_front();
          if (bin_real_o !== e.re || bin_imag_o !== e.im || done_res_o !== e.done) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected re %0d im %0d done %0b, got re %0d im %0d done %0b",
                       e.re, e.im, e.done, bin_real_o, bin_imag_o, done_res_o);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d requests pending, %0d results outstanding",
                 pending_reqs.size(), expected_bins.size());
        $display("radix2_autosort_fft regression: fail");
        $finish;
      end
    end
  end

  task automatic push_req(input r2f_pkg::mode_e m, input int unsigned i, input int r,
                          input int q);
    fft_req_t rq;
    rq.mode = m;
    rq.idx = 10'(i);
    rq.re = 16'(r);
    rq.im = 16'(q);
    pending_reqs.push_back(rq);
    if (m == r2f_pkg::ModeLoad) written[i % POINTS] = 1'b1;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid_i || expected_bins.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_direction(input bit v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    inv_dir = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int rand_sample();
    case ($urandom_range(3))
      0: return $urandom_range(65535) - 32768;
      1: return $urandom_range(511) - 256;
      2: return $urandom_range(1) ? 32767 : -32768;
      default: return $urandom_range(8191) - 4096;
    endcase
  endfunction

  // random mix of loads, reads and ignored requests, then a run and reads
  task automatic random_block(input int n);
    int unsigned i;
    int unsigned sel;
    for (int c = 0; c < n; c++) begin
      sel = $urandom_range(99);
      i = $urandom_range(POINTS - 1);
      if (sel < 45) push_req(r2f_pkg::ModeLoad, i, rand_sample(), rand_sample());
      else if (sel < 95) push_req(r2f_pkg::ModeRead, i, 0, 0);
      else push_req(r2f_pkg::ModeNone, i, rand_sample(), rand_sample());
    end
    push_req(r2f_pkg::ModeRun, $urandom_range(POINTS - 1), 0, 0);
    for (int c = 0; c < 8; c++) push_req(r2f_pkg::ModeRead, $urandom_range(POINTS - 1), 0, 0);
  endtask

  // stimulus
  initial begin
    in_stage = 1'b0;
    last_fwd = 1'b0;
    inv_dir = 1'b0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_direction(1'b0);

    // directed: extremes, ignored mode, reads of loaded entries, unscaled reads
    push_req(r2f_pkg::ModeLoad, 0, 32767, -32768);
    push_req(r2f_pkg::ModeLoad, POINTS - 1, -32768, 32767);
    push_req(r2f_pkg::ModeLoad, 1, -1, 0);
    push_req(r2f_pkg::ModeNone, 2, 32767, 32767);
    push_req(r2f_pkg::ModeRead, 0, 0, 0);
    push_req(r2f_pkg::ModeRead, POINTS - 1, 0, 0);
    push_req(r2f_pkg::ModeRead, 1, 0, 0);
    push_req(r2f_pkg::ModeLoad, 0, 0, 0);
    push_req(r2f_pkg::ModeRead, 0, 0, 0);
    push_req(r2f_pkg::ModeNone, 0, 0, 0);
    // fill the rest so the first run covers only written entries
    for (int unsigned i = 0; i < POINTS; i++)
      if (!written[i]) push_req(r2f_pkg::ModeLoad, i, rand_sample(), rand_sample());
    push_req(r2f_pkg::ModeRun, 0, 0, 0);
    push_req(r2f_pkg::ModeRead, 0, 0, 0);
    push_req(r2f_pkg::ModeRead, POINTS - 1, 0, 0);
    push_req(r2f_pkg::ModeRead, POINTS / 2, 0, 0);
    wait_idle();

    // random phases over idle schemes and both directions
    for (int p = 0; p < 8; p++) begin
      idle_scheme = idle_e'(p / 2);
      write_direction(p[0]);
      random_block(40);
      wait_idle();
    end

    // long receiver hold-off while reads keep coming
    idle_scheme = IdleNone;
    write_direction(1'b1);
    hold_go = 1'b1;
    for (int c = 0; c < 60; c++) push_req(r2f_pkg::ModeRead, $urandom_range(POINTS - 1), 0, 0);
    wait_idle();
    write_direction(1'b0);
    idle_scheme = IdleBoth;
    random_block(40);
    wait_idle();

    $display("covered %0d loads, %0d reads and %0d runs in both directions,",
             loads_seen, reads_seen, runs_seen);
    $display("with sender gaps, receiver stalls and a long output hold-off; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("radix2_autosort_fft regression: pass");
    end else begin
      $display("radix2_autosort_fft regression: fail");
    end
    $finish;
  end
endmodule
